/* design/dla_pkg.sv */
// dla_pkg: shared types and codes for the lease allocator
// no dependencies
package dla_pkg;

    typedef enum logic [2:0] {
        MODE_DISCOVER = 3'd0,
        MODE_REQUEST  = 3'd1,
        MODE_RELEASE  = 3'd2,
        MODE_DECLINE  = 3'd3,
        MODE_INFORM   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REPLY_NONE  = 2'd0,
        REPLY_OFFER = 2'd1,
        REPLY_ACK   = 2'd2,
        REPLY_NAK   = 2'd3
    } t_reply;

    typedef enum logic [1:0] {
        LS_FREE    = 2'd0,
        LS_OFFERED = 2'd1,
        LS_BOUND   = 2'd2,
        LS_EXPIRED = 2'd3
    } t_lstate;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_fsm;

    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_POOL_FIRST = 4'd0;
    localparam t_cfg_idx CFG_POOL_LAST  = 4'd1;

    localparam logic [31:0] POOL_FIRST_RST = 32'hC0A8640A;
    localparam logic [31:0] POOL_LAST_RST  = 32'hC0A864FA;

    // update command broadcast to every cell in the commit cycle
    typedef struct packed {
        logic    st_en;
        t_lstate st_val;
        logic    own_clr;
        logic    new_en;
    } t_cmd;

endpackage

/* design/dla_cell.sv */
// dla_cell: one lease entry plus one stage of the search chain
// depends on dla_pkg
module dla_cell
    import dla_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int NW  = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [47:0]   i_mac,
    input  logic [NW-1:0] i_count,
    input  logic          i_tok,
    input  logic          i_mfound,
    input  logic [IW-1:0] i_midx,
    input  t_lstate       i_mstate,
    input  logic          i_ffound,
    input  logic [IW-1:0] i_fidx,
    output logic          o_tok,
    output logic          o_mfound,
    output logic [IW-1:0] o_midx,
    output t_lstate       o_mstate,
    output logic          o_ffound,
    output logic [IW-1:0] o_fidx,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_st_idx,
    input  logic [IW-1:0] i_own_idx,
    input  logic [IW-1:0] i_new_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [NW-1:0] MY_POS = NW'(IDX);

    logic        r_valid, r_owner;
    logic [47:0] r_mac;
    t_lstate     r_state;

    logic          r_tok, r_mfound, r_ffound;
    logic [IW-1:0] r_midx, r_fidx;
    t_lstate       r_mstate;

    logic hit, usable;

    assign hit    = r_valid && r_owner && (r_mac == i_mac);
    assign usable = (MY_POS < i_count) &&
                    (!r_valid || r_state == LS_FREE || r_state == LS_EXPIRED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // first match wins: an earlier find passes through unchanged
    always_ff @(posedge i_clk) begin
        r_mfound <= i_mfound | hit;
        r_midx   <= i_mfound ? i_midx : MY_IDX;
        r_mstate <= i_mfound ? i_mstate : r_state;
        r_ffound <= i_ffound | usable;
        r_fidx   <= i_ffound ? i_fidx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_owner <= 1'b0;
        end else if (i_cmd.new_en && i_new_idx == MY_IDX) begin
            r_valid <= 1'b1;
            r_owner <= 1'b1;
        end else if (i_cmd.own_clr && i_own_idx == MY_IDX) begin
            r_owner <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.new_en && i_new_idx == MY_IDX) begin
            r_mac   <= i_mac;
            r_state <= LS_OFFERED;
        end else if (i_cmd.st_en && i_st_idx == MY_IDX && r_valid) begin
            r_state <= i_cmd.st_val;
        end
    end

    assign o_tok    = r_tok;
    assign o_mfound = r_mfound;
    assign o_midx   = r_midx;
    assign o_mstate = r_mstate;
    assign o_ffound = r_ffound;
    assign o_fidx   = r_fidx;

endmodule

/* design/dhcp_lease_allocator.sv */
// Lease pool allocator. For each accepted request a search token walks the
// row of POOL_SIZE lease cells one cell per clock, finding the client's
// owned lease and the lowest usable pool entry in the same pass; the done
// state then applies the update and loads the result register once the
// output register is free. Decline and inform skip the walk and go straight
// to the done state. One request is in flight at a time; a new one is taken
// as soon as the previous result sits in the output register. Register
// writes never clear the table, and after reset it reads as empty at once.
// depends on dla_pkg, dla_cell
module dhcp_lease_allocator
    import dla_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [47:0] i_client_mac,
    input  logic [31:0] i_option_ip,
    input  logic [31:0] i_client_ip,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_reply_kind,
    output logic [31:0] o_your_ip,
    output logic        o_to_broadcast,
    output logic        o_pool_exhausted
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int NW = IW + 1;

    logic [31:0] r_pool_first, r_pool_last;
    t_fsm        r_fsm, n_fsm;

    logic [2:0]    r_mode;
    logic [47:0]   r_mac;
    logic [31:0]   r_opt, r_ci;
    logic [NW-1:0] r_count;
    logic          r_start;

    logic          r_mfound, r_ffound;
    logic [IW-1:0] r_midx, r_fidx;
    t_lstate       r_mstate;

    logic          r_out_valid;
    t_reply        r_kind;
    logic [31:0]   r_ip;
    logic          r_bc, r_ex;

    logic          c_tok    [0:POOL_SIZE];
    logic          c_mfound [0:POOL_SIZE];
    logic [IW-1:0] c_midx   [0:POOL_SIZE];
    t_lstate       c_mstate [0:POOL_SIZE];
    logic          c_ffound [0:POOL_SIZE];
    logic [IW-1:0] c_fidx   [0:POOL_SIZE];

    t_cmd          cmd;
    logic [IW-1:0] st_idx, own_idx, new_idx;
    t_reply        n_kind;
    logic [31:0]   n_ip, m_addr, f_addr, want, dec_off, span;
    logic          n_bc, n_ex, in_acc, emit, scan_mode;
    logic [NW-1:0] cnt;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_fsm != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign scan_mode   = (i_mode == MODE_DISCOVER) || (i_mode == MODE_REQUEST) ||
                         (i_mode == MODE_RELEASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_first <= POOL_FIRST_RST;
            r_pool_last  <= POOL_LAST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POOL_FIRST: r_pool_first <= i_cfg_data;
                CFG_POOL_LAST:  r_pool_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // number of table entries the pool covers
    assign span = r_pool_last - r_pool_first;
    always_comb begin
        if (r_pool_last < r_pool_first) begin
            cnt = '0;
        end else if (span >= 32'(POOL_SIZE - 1)) begin
            cnt = NW'(POOL_SIZE);
        end else begin
            cnt = span[NW-1:0] + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_mac   <= i_client_mac;
            r_opt   <= i_option_ip;
            r_ci    <= i_client_ip;
            r_count <= cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= in_acc && scan_mode;
        end
    end

    assign c_tok[0]    = r_start;
    assign c_mfound[0] = 1'b0;
    assign c_midx[0]   = '0;
    assign c_mstate[0] = LS_FREE;
    assign c_ffound[0] = 1'b0;
    assign c_fidx[0]   = '0;

    for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
        dla_cell #(.IDX(g), .IW(IW), .NW(NW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_mac     (r_mac),
            .i_count   (r_count),
            .i_tok     (c_tok[g]),
            .i_mfound  (c_mfound[g]),
            .i_midx    (c_midx[g]),
            .i_mstate  (c_mstate[g]),
            .i_ffound  (c_ffound[g]),
            .i_fidx    (c_fidx[g]),
            .o_tok     (c_tok[g+1]),
            .o_mfound  (c_mfound[g+1]),
            .o_midx    (c_midx[g+1]),
            .o_mstate  (c_mstate[g+1]),
            .o_ffound  (c_ffound[g+1]),
            .o_fidx    (c_fidx[g+1]),
            .i_cmd     (cmd),
            .i_st_idx  (st_idx),
            .i_own_idx (own_idx),
            .i_new_idx (new_idx)
        );
    end

    always_ff @(posedge i_clk) begin
        if (c_tok[POOL_SIZE]) begin
            r_mfound <= c_mfound[POOL_SIZE];
            r_midx   <= c_midx[POOL_SIZE];
            r_mstate <= c_mstate[POOL_SIZE];
            r_ffound <= c_ffound[POOL_SIZE];
            r_fidx   <= c_fidx[POOL_SIZE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    assign emit = (r_fsm == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE: if (in_acc) n_fsm = scan_mode ? S_SCAN : S_DONE;
            S_SCAN: if (c_tok[POOL_SIZE]) n_fsm = S_DONE;
            S_DONE: if (emit) n_fsm = S_IDLE;
            default: n_fsm = S_IDLE;
        endcase
    end

    assign m_addr  = r_pool_first + 32'(r_midx);
    assign f_addr  = r_pool_first + 32'(r_fidx);
    assign want    = (r_opt != 32'd0) ? r_opt : r_ci;
    assign dec_off = r_opt - r_pool_first;

    always_comb begin
        cmd     = '0;
        st_idx  = r_midx;
        own_idx = r_midx;
        new_idx = r_fidx;
        n_kind  = REPLY_NONE;
        n_ip    = '0;
        n_bc    = 1'b0;
        n_ex    = 1'b0;
        unique case (r_mode)
            MODE_DISCOVER: begin
                if (r_mfound && r_mstate != LS_EXPIRED) begin
                    cmd.st_en  = 1'b1;
                    cmd.st_val = LS_OFFERED;
                    n_kind     = REPLY_OFFER;
                    n_ip       = m_addr;
                    n_bc       = 1'b1;
                end else if (!r_ffound) begin
                    n_ex = 1'b1;
                end else begin
                    cmd.own_clr = r_mfound;
                    cmd.new_en  = 1'b1;
                    n_kind      = REPLY_OFFER;
                    n_ip        = f_addr;
                    n_bc        = 1'b1;
                end
            end
            MODE_REQUEST: begin
                n_bc = 1'b1;
                if (r_mfound && m_addr == want) begin
                    cmd.st_en  = 1'b1;
                    cmd.st_val = LS_BOUND;
                    n_kind     = REPLY_ACK;
                    n_ip       = want;
                end else begin
                    n_kind = REPLY_NAK;
                end
            end
            MODE_RELEASE: begin
                cmd.st_en  = r_mfound;
                cmd.st_val = LS_FREE;
            end
            MODE_DECLINE: begin
                // the cell drops the update if its entry is not valid
                cmd.st_en  = (dec_off < 32'(POOL_SIZE));
                cmd.st_val = LS_EXPIRED;
                st_idx     = dec_off[IW-1:0];
            end
            MODE_INFORM: begin
                n_kind = REPLY_ACK;
                n_ip   = r_ci;
            end
            default: ;
        endcase
        if (!emit) begin
            cmd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= n_kind;
            r_ip   <= n_ip;
            r_bc   <= n_bc;
            r_ex   <= n_ex;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_reply_kind     = r_kind;
    assign o_your_ip        = r_ip;
    assign o_to_broadcast   = r_bc;
    assign o_pool_exhausted = r_ex;

endmodule

/* design/dla_check.sv */
// dla_check: port-level checks for the lease allocator, bound to the top
// depends on dla_pkg
module dla_check
    import dla_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_reply_kind,
    input logic [31:0] o_your_ip,
    input logic        o_to_broadcast,
    input logic        o_pool_exhausted
);

    // a result waiting under stall stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_your_ip))
        else $error("result dropped or changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    a_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pool_exhausted |->
            o_reply_kind == REPLY_NONE && o_your_ip == 32'd0)
        else $error("exhausted result carries a reply");

    a_nak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reply_kind == REPLY_NAK |->
            o_your_ip == 32'd0 && o_to_broadcast)
        else $error("nak with address or unicast");

endmodule

bind dhcp_lease_allocator dla_check u_dla_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_reply_kind     (o_reply_kind),
    .o_your_ip        (o_your_ip),
    .o_to_broadcast   (o_to_broadcast),
    .o_pool_exhausted (o_pool_exhausted)
);

/* tb/testbench.sv */
// testbench for dhcp_lease_allocator: directed and random lease traffic,
// results checked against an in-bench lease table predictor
// depends on dla_pkg and the dhcp_lease_allocator rtl
`timescale 1ns / 100ps
module testbench;
    import dla_pkg::*;

    localparam int TBL = 256;
    localparam int WDOG_LIMIT = 20000;
    localparam string PASS_MSG = "** dhcp_lease_allocator: PASSED **";

    typedef struct packed {
        t_reply      kind;
        logic [31:0] yip;
        logic        bcast;
        logic        exh;
    } t_reply_rec;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    t_cfg_idx    cfg_index = CFG_POOL_FIRST;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [47:0] mac = '0;
    logic [31:0] opt_ip = '0;
    logic [31:0] ci_ip = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  reply_kind;
    logic [31:0] your_ip;
    logic        to_bcast;
    logic        exhausted;

    // predictor copy of the lease table and pool registers
    logic [31:0] pool_lo;
    logic [31:0] pool_hi;
    logic        lt_valid [TBL];
    logic        lt_owner [TBL];
    logic [47:0] lt_mac   [TBL];
    t_lstate     lt_state [TBL];

    t_reply_rec  pending_replies[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_offers = 0;
    int          n_exh = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;
    logic [47:0] macs[16];

    dhcp_lease_allocator #(.POOL_SIZE(TBL)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_client_mac(mac), .i_option_ip(opt_ip), .i_client_ip(ci_ip),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_reply_kind(reply_kind), .o_your_ip(your_ip),
        .o_to_broadcast(to_bcast), .o_pool_exhausted(exhausted)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int owned_entry(logic [47:0] m);
        for (int k = 0; k < TBL; k++)
            if (lt_valid[k] && lt_owner[k] && lt_mac[k] == m) return k;
        return -1;
    endfunction

    function automatic t_reply_rec lease_reply(logic [2:0] md, logic [47:0] m,
                                               logic [31:0] oip, logic [31:0] cip);
        t_reply_rec r;
        int k;
        int n;
        int i;
        logic [31:0] want;
        logic [31:0] off;
        r = '{REPLY_NONE, 32'd0, 1'b0, 1'b0};
        case (md)
            MODE_DISCOVER: begin
                k = owned_entry(m);
                if (k >= 0 && lt_state[k] != LS_EXPIRED) begin
                    lt_state[k] = LS_OFFERED;
                    return '{REPLY_OFFER, pool_lo + k, 1'b1, 1'b0};
                end
                if (pool_hi < pool_lo) n = 0;
                else if (pool_hi - pool_lo >= TBL - 1) n = TBL;
                else n = pool_hi - pool_lo + 1;
                for (i = 0; i < n; i++)
                    if (!lt_valid[i] || lt_state[i] == LS_FREE
                            || lt_state[i] == LS_EXPIRED) break;
                if (i >= n) return '{REPLY_NONE, 32'd0, 1'b0, 1'b1};
                if (k >= 0) lt_owner[k] = 1'b0;
                lt_valid[i] = 1'b1;
                lt_owner[i] = 1'b1;
                lt_mac[i] = m;
                lt_state[i] = LS_OFFERED;
                r = '{REPLY_OFFER, pool_lo + i, 1'b1, 1'b0};
            end
            MODE_REQUEST: begin
                want = (oip != 0) ? oip : cip;
                k = owned_entry(m);
                if (k >= 0 && pool_lo + k == want) begin
                    lt_state[k] = LS_BOUND;
                    r = '{REPLY_ACK, want, 1'b1, 1'b0};
                end else begin
                    r = '{REPLY_NAK, 32'd0, 1'b1, 1'b0};
                end
            end
            MODE_RELEASE: begin
                k = owned_entry(m);
                if (k >= 0) lt_state[k] = LS_FREE;
            end
            MODE_DECLINE: begin
                off = oip - pool_lo;
                if (off < TBL && lt_valid[off]) lt_state[off] = LS_EXPIRED;
            end
            MODE_INFORM: r = '{REPLY_ACK, cip, 1'b0, 1'b0};
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(logic [2:0] md, logic [47:0] m,
                                logic [31:0] oip, logic [31:0] cip);
        while (!calm && $urandom_range(99) < 20) @(posedge clk);
        in_valid <= 1'b1;
        mode <= md;
        mac <= m;
        opt_ip <= oip;
        ci_ip <= cip;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_replies.push_back(lease_reply(md, m, oip, cip));
        n_sent++;
        in_valid <= 1'b0;
        // the block raises its stall after taking a request
        @(posedge clk);
    endtask

    // pool registers are only written with nothing in flight
    task automatic write_pool(t_cfg_idx idx, logic [31:0] val);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (TBL + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_POOL_FIRST) pool_lo = val;
        else pool_hi = val;
    endtask

    always @(posedge clk) begin
        if (rst_n) out_stall <= !calm && ($urandom_range(99) < 20);
    end

    always @(posedge clk) begin
        t_reply_rec exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply kind=%0d ip=%h", reply_kind, your_ip);
                errors++;
            end else begin
                exp_r = pending_replies.pop_front();
                n_checked++;
                if (exp_r.kind == REPLY_OFFER) n_offers++;
                if (exp_r.exh) n_exh++;
                if (reply_kind !== exp_r.kind) begin
                    $error("reply_kind exp %0d got %0d", exp_r.kind, reply_kind);
                    errors++;
                end
                if (your_ip !== exp_r.yip) begin
                    $error("your_ip exp %h got %h", exp_r.yip, your_ip);
                    errors++;
                end
                if (to_bcast !== exp_r.bcast) begin
                    $error("to_broadcast exp %0d got %0d", exp_r.bcast, to_bcast);
                    errors++;
                end
                if (exhausted !== exp_r.exh) begin
                    $error("pool_exhausted exp %0d got %0d", exp_r.exh, exhausted);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("watchdog expired, %0d replies outstanding", pending_replies.size());
            $display("** dhcp_lease_allocator: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] rand32();
        return $urandom;
    endfunction

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic test_directed();
        // default pool, extremes of fields, every mode, unknown modes
        send_request(MODE_DISCOVER, 48'h0, 32'h0, 32'h0);
        send_request(MODE_DISCOVER, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_REQUEST, 48'h0, POOL_FIRST_RST, 32'h0);
        send_request(MODE_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0, POOL_FIRST_RST + 1);
        send_request(MODE_REQUEST, 48'h0, 32'h0, 32'h0);
        send_request(MODE_DISCOVER, 48'h0, 32'h0, 32'h0);
        send_request(MODE_RELEASE, 48'h0, 32'h0, 32'h0);
        send_request(MODE_RELEASE, 48'h1234, 32'h0, 32'h0);
        send_request(MODE_DISCOVER, 48'h55, 32'h0, 32'h0);
        send_request(MODE_DECLINE, 48'h0, POOL_FIRST_RST + 1, 32'h0);
        send_request(MODE_DECLINE, 48'h0, 32'h0, POOL_FIRST_RST);
        // expired lease: the same entry is offered to the client again as a new lease
        send_request(MODE_DISCOVER, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0);
        send_request(MODE_REQUEST, 48'hFFFF_FFFF_FFFF, POOL_FIRST_RST + 1, 32'h0);
        send_request(MODE_INFORM, 48'hAA, 32'h0, 32'hFFFF_FFFF);
        send_request(MODE_INFORM, 48'hAA, 32'h0, 32'h0);
        for (int m = 5; m < 8; m++) send_request(3'(m), 48'hFFFF_FFFF_FFFF, '1, '1);
    endtask

    task automatic test_tiny_pool();
        // two-entry pool with both entries already taken, then empty pool
        write_pool(CFG_POOL_FIRST, 32'h0000_0000);
        write_pool(CFG_POOL_LAST, 32'h0000_0001);
        for (int i = 0; i < 4; i++) send_request(MODE_DISCOVER, 48'h100 + i, 0, 0);
        send_request(MODE_REQUEST, 48'h101, 32'h0, 32'h1);
        write_pool(CFG_POOL_FIRST, 32'hFFFF_FFFF);
        write_pool(CFG_POOL_LAST, 32'h0000_0000);
        send_request(MODE_DISCOVER, 48'h200, 0, 0);
        send_request(MODE_DISCOVER, 48'h100, 0, 0);
    endtask

    task automatic random_phase(int count, logic [31:0] lo, logic [31:0] hi);
        int sel;
        int k;
        logic [47:0] m;
        logic [31:0] a;
        write_pool(CFG_POOL_FIRST, lo);
        write_pool(CFG_POOL_LAST, hi);
        for (int j = 0; j < count; j++) begin
            sel = $urandom_range(99);
            m = ($urandom_range(9) == 0) ? rand_mac() : macs[$urandom_range(15)];
            k = owned_entry(m);
            a = (k >= 0) ? pool_lo + k : pool_lo + $urandom_range(TBL - 1);
            if (sel < 30) send_request(MODE_DISCOVER, m, rand32(), rand32());
            else if (sel < 55) begin
                if ($urandom_range(1)) send_request(MODE_REQUEST, m, a, rand32());
                else send_request(MODE_REQUEST, m, 32'h0, a);
            end else if (sel < 65) send_request(MODE_REQUEST, m, rand32(), rand32());
            else if (sel < 77) send_request(MODE_RELEASE, m, rand32(), rand32());
            else if (sel < 87) send_request(MODE_DECLINE, m,
                                            $urandom_range(3) ? a : rand32(), rand32());
            else if (sel < 95) send_request(MODE_INFORM, m, rand32(), rand32());
            else send_request(3'($urandom_range(7)), rand_mac(), rand32(), rand32());
        end
    endtask

    initial begin
        pool_lo = POOL_FIRST_RST;
        pool_hi = POOL_LAST_RST;
        for (int k = 0; k < TBL; k++) begin
            lt_valid[k] = 1'b0;
            lt_owner[k] = 1'b0;
            lt_mac[k] = '0;
            lt_state[k] = LS_FREE;
        end
        for (int i = 0; i < 16; i++) macs[i] = rand_mac();
        macs[0] = 48'h0;
        macs[1] = 48'hFFFF_FFFF_FFFF;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tiny_pool();
        random_phase(250, 32'h0A00_0000, 32'h0A00_0007);
        calm = 1'b1;
        random_phase(100, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        calm = 1'b0;
        random_phase(250, POOL_FIRST_RST, POOL_LAST_RST);
        random_phase(250, 32'h8000_0000, 32'hFFFF_FFFF);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (TBL + 8) @(posedge clk);
        $display("sent %0d requests, checked %0d replies (%0d offers, %0d exhausted)",
                 n_sent, n_checked, n_offers, n_exh);
        $display("pool settings covered: default, tiny, empty, wrapped, full-range");
        if (errors == 0) $display(PASS_MSG);
        else $display("** dhcp_lease_allocator: FAILED **");
        $finish;
    end
endmodule
